@@ sv/substring_search_from_offset_top_assert.svh @@
// Assertion macros shared by the substring search RTL.
// Depends on the including module having clk and arst_n in scope.
`ifndef SUBSTRING_SEARCH_FROM_OFFSET_TOP_ASSERT_SVH
`define SUBSTRING_SEARCH_FROM_OFFSET_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SSFO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SSFO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSFO_ASSERT_IMP(label, ante, cons, msg)
`define SSFO_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ sv/ssfo_pkg.sv @@
// Types and constants for the substring search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ssfo_pkg;

	localparam int CHAR_W      = 16;
	localparam int OFFSET_W    = 16;
	localparam int POS_W       = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic {
		CMD_PATTERN = 1'b0,
		CMD_TEXT    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_OFFSET       = 2'd1,
		ERR_PATTERN_LONG = 2'd2,
		ERR_TEXT_LONG    = 2'd3
	} err_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  match_position;
		err_t              error_code;
	} result_t;

	typedef struct packed {
		logic shift_pattern;
		logic shift_text;
	} cell_ctrl_t;

endpackage

@@ sv/substring_search_from_offset_top.sv @@
// Top level of the substring search: pattern/text cell chain and result logic.
// Depends on ssfo_pkg, ssfo_cell, ssfo_result_buf and the assertion macro header.
//
//   channel   dir  tdata                                   tuser     tlast
//   s_axis    in   char_value[15:0] start_offset[31:16]    command   last_item
//   m_axis    out  found[0] match_position[16:1]           -         -
//                  error_code[18:17], zero pad to 24 bits
//
// A new request is accepted every cycle while the result buffer is not full.
// The result of a text ending is registered in the output register, or in the skid register while that is held.
// The cell chain compares all cells in the cycle that a text character is accepted, and shifts the window then.
// Reset clears all control state at once; there is no clearing pass.
// Input ready drops only while two results wait for the output side.
`timescale 1ns / 1ps
`include "substring_search_from_offset_top_assert.svh"
module substring_search_from_offset_top import ssfo_pkg::*; #(
	parameter int PATTERN_MAX = 16,
	parameter int TEXT_MAX    = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // char_value, start_offset
	input  logic                   s_axis_tuser,  // command
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // found, match_position, error_code
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W = $clog2(TEXT_MAX + 2);
	localparam int CMP_W = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 1;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TEXT_MAX);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(TEXT_MAX + 1);

	cmd_t                in_cmd;
	logic [CHAR_W-1:0]   in_char;
	logic [OFFSET_W-1:0] in_offset;
	logic                in_last;
	logic                accept;

	logic [LEN_W-1:0]    pat_len_q;
	logic                pat_ovf_q;
	logic                pat_restart_q;
	logic [CNT_W-1:0]    txt_cnt_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                seen_q;
	logic [POS_W-1:0]    first_pos_q;

	cell_ctrl_t          ctrl;
	logic [LEN_W-1:0]    pat_len_eff;
	logic [CHAR_W-1:0]   pat_chain [PATTERN_MAX];
	logic [CHAR_W-1:0]   txt_chain [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit;
	logic                window_match;

	logic [CNT_W-1:0]    cnt_new;
	logic                first_char;
	logic [OFFSET_W-1:0] offset_eff;
	logic                seen_eff;
	logic [POS_W-1:0]    pos_eff;
	logic [CMP_W-1:0]    cnt_x;
	logic [CMP_W-1:0]    off_x;
	logic [CMP_W-1:0]    len_x;
	logic                hit_now;
	logic                seen_new;
	logic [POS_W-1:0]    pos_new;

	result_t             res;
	logic                res_push;
	logic                buf_full;
	result_t             out_res;

	assign in_cmd    = cmd_t'(s_axis_tuser);
	assign in_char   = s_axis_tdata[CHAR_W-1:0];
	assign in_offset = s_axis_tdata[CHAR_W+OFFSET_W-1:CHAR_W];
	assign in_last   = s_axis_tlast;
	assign accept    = s_axis_tvalid && s_axis_tready;

	// A new pattern starts empty, so the first character always fits.
	assign pat_len_eff        = pat_restart_q ? '0 : pat_len_q;
	assign ctrl.shift_pattern = accept && (in_cmd == CMD_PATTERN) && (pat_len_eff < LEN_MAX);
	assign ctrl.shift_text    = accept && (in_cmd == CMD_TEXT);

	// Both chains shift toward higher cells, so cell k holds the pattern
	// character that lines up with the text character k places back.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		ssfo_cell #(
			.CELL_INDEX(k),
			.LEN_W     (LEN_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pattern_in ((k == 0) ? in_char : pat_chain[(k == 0) ? 0 : k - 1]),
			.text_in    ((k == 0) ? in_char : txt_chain[(k == 0) ? 0 : k - 1]),
			.pattern_len(pat_len_q),
			.pattern_out(pat_chain[k]),
			.text_out   (txt_chain[k]),
			.hit        (hit[k])
		);
	end

	assign window_match = &hit;

	assign cnt_new    = (txt_cnt_q <= CNT_MAX) ? txt_cnt_q + CNT_W'(1) : txt_cnt_q;
	assign first_char = (txt_cnt_q == '0);
	assign offset_eff = first_char ? in_offset : offset_q;
	assign seen_eff   = first_char ? 1'b0 : seen_q;
	assign pos_eff    = first_char ? '0 : first_pos_q;

	assign cnt_x = CMP_W'(cnt_new);
	assign off_x = CMP_W'(offset_eff);
	assign len_x = CMP_W'(pat_len_q);

	// The match start is the text count minus the pattern length, and it must
	// not lie before the offset.
	assign hit_now  = !seen_eff && (pat_len_q != '0) && (cnt_new <= CNT_MAX)
		&& (cnt_x >= off_x + len_x) && window_match;
	assign seen_new = seen_eff || hit_now;
	assign pos_new  = hit_now ? POS_W'(cnt_x - len_x) : pos_eff;

	always_comb begin
		res.found          = 1'b0;
		res.match_position = '0;
		res.error_code     = ERR_NONE;
		priority if (cnt_new > CNT_MAX) begin
			res.error_code = ERR_TEXT_LONG;
		end else if (off_x > cnt_x) begin
			res.error_code = ERR_OFFSET;
		end else if (off_x == cnt_x) begin
			res.error_code = ERR_NONE;
		end else if (pat_ovf_q) begin
			res.error_code = ERR_PATTERN_LONG;
		end else if (seen_new) begin
			res.found          = 1'b1;
			res.match_position = pos_new;
		end
	end

	assign res_push = ctrl.shift_text && in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q     <= '0;
			pat_ovf_q     <= 1'b0;
			pat_restart_q <= 1'b1;
			txt_cnt_q     <= '0;
			offset_q      <= '0;
			seen_q        <= 1'b0;
			first_pos_q   <= '0;
		end else if (accept) begin
			unique case (in_cmd)
				CMD_PATTERN: begin
					pat_restart_q <= in_last;
					if (pat_len_eff < LEN_MAX) begin
						pat_len_q <= pat_len_eff + LEN_W'(1);
						pat_ovf_q <= pat_restart_q ? 1'b0 : pat_ovf_q;
					end else begin
						pat_len_q <= pat_len_eff;
						pat_ovf_q <= 1'b1;
					end
				end
				CMD_TEXT: begin
					offset_q    <= offset_eff;
					first_pos_q <= pos_new;
					if (in_last) begin
						txt_cnt_q <= '0;
						seen_q    <= 1'b0;
					end else begin
						txt_cnt_q <= cnt_new;
						seen_q    <= seen_new;
					end
				end
				default: begin
					pat_restart_q <= pat_restart_q;
				end
			endcase
		end
	end

	ssfo_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res),
		.full     (buf_full),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_res)
	);

	assign s_axis_tready = !buf_full;
	assign m_axis_tdata  = {
		(OUT_TDATA_W - POS_W - 3)'(0),
		out_res.error_code,
		out_res.match_position,
		out_res.found
	};

	`SSFO_ASSERT_IMP(a_cnt_saturates, 1'b1, txt_cnt_q <= CNT_SAT, "text count past saturation")
	`SSFO_ASSERT_IMP(a_err_not_found, res_push && (res.error_code != ERR_NONE), !res.found,
		"error result reports a match")
	`SSFO_ASSERT_NXT(a_restart_after_last, accept && (in_cmd == CMD_PATTERN) && in_last,
		pat_restart_q, "pattern end did not arm restart")

endmodule

@@ sv/ssfo_cell.sv @@
// One cell of the search chain: holds one pattern character and one text character.
// Depends on ssfo_pkg.
`timescale 1ns / 1ps
module ssfo_cell import ssfo_pkg::*; #(
	parameter int CELL_INDEX = 0,
	parameter int LEN_W      = 5
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [CHAR_W-1:0] pattern_in,
	input  logic [CHAR_W-1:0] text_in,
	input  logic [LEN_W-1:0]  pattern_len,
	output logic [CHAR_W-1:0] pattern_out,
	output logic [CHAR_W-1:0] text_out,
	output logic              hit
);

	localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_INDEX);

	logic [CHAR_W-1:0] pattern_q;
	logic [CHAR_W-1:0] text_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_pattern) begin
			pattern_q <= pattern_in;
		end
		if (ctrl.shift_text) begin
			text_q <= text_in;
		end
	end

	// The incoming text character is the one this cell holds after the shift,
	// so it is compared against the pattern character stored here. Cells past
	// the pattern length do not take part.
	assign hit         = (text_in == pattern_q) || (pattern_len <= IDX);
	assign pattern_out = pattern_q;
	assign text_out    = text_q;

endmodule

@@ sv/ssfo_result_buf.sv @@
// Two-entry result buffer: an output register and a skid register.
// Depends on ssfo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "substring_search_from_offset_top_assert.svh"
module ssfo_result_buf import ssfo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    pop;

	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (pop || !out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (pop || !out_valid_q) begin
			out_data_q <= push_data;
		end else begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SSFO_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full while output empty")
	`SSFO_ASSERT_IMP(a_no_push_when_full, push, !skid_valid_q, "result pushed into full buffer")
	`SSFO_ASSERT_NXT(a_skid_drains, skid_valid_q && pop, out_valid_q && !skid_valid_q,
		"skid entry not moved to output")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the substring search block: directed table, overflow and stall cases, random runs.
// Depends on ssfo_pkg and substring_search_from_offset_top; predicts results in its own model or uses typed ones.
`timescale 1ns / 1ps
module tb_top;
	import ssfo_pkg::*;

	localparam int PAT_MAX      = 16;
	localparam int TEXT_MAX     = 65536;
	localparam int RANDOM_ITEMS = 1290;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 300;
	localparam result_t NO_RESULT = '{1'b0, 16'd0, ERR_NONE};

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] ch;
		logic [15:0] off;
		logic        last;
		logic        typed;
		result_t     res;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // char_value[15:0], start_offset[31:16]
	logic                   s_axis_tuser;   // command
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // found[0], match_position[16:1], error_code[18:17]

	// Hand-written expectation that travels with the request that ends a text.
	logic    req_typed;
	result_t req_typed_res;

	bit idle_on;
	bit hold_output;
	int items_sent;
	int mismatch_count;

	result_t results_due[$];

	// Search state mirrored from the block.
	logic [15:0] pat_chars[PAT_MAX];
	int unsigned pat_len     = 0;
	bit          pat_over    = 1'b0;
	bit          pat_fresh   = 1'b1;
	logic [15:0] win_chars[PAT_MAX] = '{default: 16'h0000};
	int unsigned text_len    = 0;
	logic [15:0] held_offset = 16'h0000;
	bit          hit_found   = 1'b0;
	logic [15:0] hit_pos     = 16'h0000;

	stim_row_t directed_rows[17] = '{
		'{CMD_TEXT,    16'h0000, 16'h0000, 1'b1, 1'b1, '{1'b0, 16'd0, ERR_NONE}},
		'{CMD_PATTERN, 16'h0041, 16'h0000, 1'b0, 1'b0, NO_RESULT},
		'{CMD_PATTERN, 16'hFFFF, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0041, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'hFFFF, 16'h0000, 1'b1, 1'b1, '{1'b1, 16'd1, ERR_NONE}},
		'{CMD_TEXT,    16'h0041, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 16'd0, ERR_OFFSET}},
		'{CMD_TEXT,    16'h0041, 16'h0001, 1'b0, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'hFFFF, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0041, 16'h0002, 1'b0, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'hFFFF, 16'h0000, 1'b1, 1'b1, '{1'b0, 16'd0, ERR_NONE}},
		'{CMD_TEXT,    16'h0061, 16'h0000, 1'b0, 1'b0, NO_RESULT},
		'{CMD_PATTERN, 16'h0062, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0062, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0000, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_PATTERN, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_RESULT},
		'{CMD_TEXT,    16'h0000, 16'h0000, 1'b1, 1'b1, '{1'b1, 16'd0, ERR_NONE}}
	};

	substring_search_from_offset_top #(
		.PATTERN_MAX(PAT_MAX),
		.TEXT_MAX   (TEXT_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic result_t outcome(input bit f, input logic [15:0] p, input err_t e);
		result_t r;
		r.found = f;
		r.match_position = p;
		r.error_code = e;
		return r;
	endfunction

	// Advances the mirrored state by one request; returns 1 when the request ends a text.
	function automatic bit search_step(input cmd_t cmd, input logic [15:0] ch,
			input logic [15:0] off, input bit last, output result_t res);
		int unsigned start;
		int i;
		bit same;
		res = NO_RESULT;
		if (cmd == CMD_PATTERN) begin
			if (pat_fresh) begin
				pat_len = 0;
				pat_over = 1'b0;
				pat_fresh = 1'b0;
			end
			if (pat_len < PAT_MAX) begin
				pat_chars[pat_len] = ch;
				pat_len++;
			end else begin
				pat_over = 1'b1;
			end
			if (last)
				pat_fresh = 1'b1;
			return 1'b0;
		end
		if (text_len == 0) begin
			held_offset = off;
			hit_found = 1'b0;
			hit_pos = 16'h0000;
		end
		for (i = PAT_MAX - 1; i > 0; i--)
			win_chars[i] = win_chars[i - 1];
		win_chars[0] = ch;
		if (text_len <= TEXT_MAX)
			text_len++;
		if (!hit_found && pat_len > 0 && text_len <= TEXT_MAX && text_len >= pat_len) begin
			start = text_len - pat_len;
			same = 1'b1;
			for (i = 0; i < pat_len; i++)
				if (pat_chars[i] != win_chars[pat_len - 1 - i])
					same = 1'b0;
			if (start >= held_offset && same) begin
				hit_found = 1'b1;
				hit_pos = start[15:0];
			end
		end
		if (!last)
			return 1'b0;
		// Error precedence: text too long, then offset past the end, then an offset
		// at the end (plain miss), then pattern overflow.
		if (text_len > TEXT_MAX)
			res.error_code = ERR_TEXT_LONG;
		else if (held_offset > text_len)
			res.error_code = ERR_OFFSET;
		else if (held_offset == text_len)
			res.error_code = ERR_NONE;
		else if (pat_over)
			res.error_code = ERR_PATTERN_LONG;
		else if (hit_found) begin
			res.found = 1'b1;
			res.match_position = hit_pos;
		end
		text_len = 0;
		hit_found = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		result_t predicted;
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (search_step(cmd_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16],
						s_axis_tlast, predicted))
					results_due.push_back(req_typed ? req_typed_res : predicted);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.found = m_axis_tdata[0];
				got.match_position = m_axis_tdata[16:1];
				got.error_code = err_t'(m_axis_tdata[18:17]);
				if (results_due.size() == 0) begin
					$display("%0t ns: expected no result, actual found %0d position %0d error %0d",
						$time, got.found, got.match_position, got.error_code);
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					if (got.found !== want.found) begin
						$display("%0t ns: found expected %0d, actual %0d",
							$time, want.found, got.found);
						mismatch_count++;
					end
					if (got.match_position !== want.match_position) begin
						$display("%0t ns: match_position expected %0d, actual %0d",
							$time, want.match_position, got.match_position);
						mismatch_count++;
					end
					if (got.error_code !== want.error_code) begin
						$display("%0t ns: error_code expected %0d, actual %0d",
							$time, want.error_code, got.error_code);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_output <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	task automatic send_char(input cmd_t cmd, input logic [15:0] ch, input logic [15:0] off,
			input bit last, input bit typed = 1'b0, input result_t typed_res = NO_RESULT);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {off, ch};
		s_axis_tlast <= last;
		req_typed <= typed;
		req_typed_res <= typed_res;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int k;
		int n;
		int plen;
		int tlen;
		int at;
		int rand_base;
		bit keep_last;
		logic [15:0] off;
		logic [15:0] sym[3];
		logic [15:0] pbuf[20];
		logic [15:0] tbuf[48];

		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_PATTERN;
		s_axis_tlast = 1'b0;
		req_typed = 1'b0;
		req_typed_res = NO_RESULT;
		idle_on = 1'b1;
		hold_output = 1'b0;
		items_sent = 0;
		mismatch_count = 0;
		plen = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_char(directed_rows[r].cmd, directed_rows[r].ch, directed_rows[r].off,
				directed_rows[r].last, directed_rows[r].typed, directed_rows[r].res);

		// Seventeen pattern characters: the last one is dropped and flags overflow.
		for (k = 0; k < 17; k++)
			send_char(CMD_PATTERN, 16'(k), 16'h0000, k == 16);
		for (k = 0; k < 4; k++)
			send_char(CMD_TEXT, 16'(k), 16'h0000, k == 3, 1'b1,
				outcome(1'b0, 16'd0, ERR_PATTERN_LONG));
		for (k = 0; k < 2; k++)
			send_char(CMD_TEXT, 16'(k), 16'h0002, k == 1, 1'b1, outcome(1'b0, 16'd0, ERR_NONE));
		for (k = 0; k < 2; k++)
			send_char(CMD_TEXT, 16'(k), 16'h0003, k == 1, 1'b1, outcome(1'b0, 16'd0, ERR_OFFSET));

		// A full-width pattern found after three leading characters.
		for (k = 0; k < PAT_MAX; k++)
			send_char(CMD_PATTERN, 16'h8000 | 16'(k), 16'h0000, k == PAT_MAX - 1);
		for (k = 0; k < PAT_MAX + 3; k++)
			send_char(CMD_TEXT, (k < 3) ? 16'h0000 : (16'h8000 | 16'(k - 3)),
				(k == 0) ? 16'h0003 : 16'h7FFF, k == PAT_MAX + 2, 1'b1,
				outcome(1'b1, 16'd3, ERR_NONE));
		wait_idle();

		// The output side holds off while requests keep coming, so the input stalls.
		idle_on = 1'b0;
		hold_output <= 1'b1;
		for (k = 0; k < 80; k++)
			send_char(CMD_TEXT, 16'($urandom), 16'h0000, 1'b1);
		wait_idle();

		// A one-character pattern found at the last text position, right at the offset.
		send_char(CMD_PATTERN, 16'h005A, 16'h0000, 1'b1);
		for (k = 0; k < 8; k++)
			send_char(CMD_TEXT, (k == 7) ? 16'h005A : 16'h0000, (k == 0) ? 16'h0007 : 16'hFFFF,
				k == 7, 1'b1, outcome(1'b1, 16'd7, ERR_NONE));
		wait_idle();
		plen = 1;
		pbuf[0] = 16'h005A;

		// Random runs: mostly a pattern load followed by a text that often contains it.
		idle_on = 1'b1;
		rand_base = items_sent;
		while (items_sent - rand_base < RANDOM_ITEMS) begin
			if (items_sent - rand_base > RANDOM_ITEMS - 150)
				idle_on = 1'b0;
			for (k = 0; k < 3; k++) begin
				sym[k] = 16'($urandom);
				if ($urandom_range(0, 1) == 1)
					sym[k][15:8] = 8'h00;
			end
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 9) == 0)
					plen = $urandom_range(17, 20);
				else if ($urandom_range(0, 2) == 0)
					plen = $urandom_range(5, 16);
				else
					plen = $urandom_range(1, 4);
				// Now and then the pattern is left open, so the next load appends to it.
				keep_last = ($urandom_range(0, 19) != 0);
				for (k = 0; k < plen; k++) begin
					pbuf[k] = sym[$urandom_range(0, 2)];
					send_char(CMD_PATTERN, pbuf[k], 16'($urandom), keep_last && k == plen - 1);
				end
			end
			tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
			for (k = 0; k < tlen; k++)
				tbuf[k] = sym[$urandom_range(0, 2)];
			n = (plen > PAT_MAX) ? PAT_MAX : plen;
			at = 0;
			if (n <= tlen && $urandom_range(0, 3) != 0) begin
				at = $urandom_range(0, tlen - n);
				for (k = 0; k < n; k++)
					tbuf[at + k] = pbuf[k];
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: off = 16'($urandom_range(0, tlen));
				6, 7: off = 16'(at + $urandom_range(0, 1));
				8: off = 16'(tlen + $urandom_range(1, 3));
				default: off = 16'($urandom);
			endcase
			for (k = 0; k < tlen; k++) begin
				if ($urandom_range(0, 39) == 0)
					send_char(CMD_PATTERN, sym[0], 16'($urandom), 1'b1);
				send_char(CMD_TEXT, tbuf[k], (k == 0) ? off : 16'($urandom), k == tlen - 1);
			end
		end
		wait_idle();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
